@@ design/astok_pkg.sv @@
// shared types, token kinds and character codes for the assembly source tokenizer
package astok_pkg;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_COMMENT = 4'b0010,
		MODE_WORD    = 4'b0100,
		MODE_NUMBER  = 4'b1000
	} scan_mode_t;

	localparam logic [3:0] KIND_EOF    = 4'd0;
	localparam logic [3:0] KIND_IDENT  = 4'd1;
	localparam logic [3:0] KIND_INT    = 4'd2;
	localparam logic [3:0] KIND_UNDEF  = 4'd3;
	localparam logic [3:0] KIND_NOP    = 4'd4;
	localparam logic [3:0] KIND_ADD    = 4'd5;
	localparam logic [3:0] KIND_SUB    = 4'd6;
	localparam logic [3:0] KIND_CMP    = 4'd7;
	localparam logic [3:0] KIND_JA     = 4'd8;
	localparam logic [3:0] KIND_JB     = 4'd9;
	localparam logic [3:0] KIND_JE     = 4'd10;
	localparam logic [3:0] KIND_JMP    = 4'd11;
	localparam logic [3:0] KIND_MOV    = 4'd12;
	localparam logic [3:0] KIND_COMMA  = 4'd13;
	localparam logic [3:0] KIND_DOLLAR = 4'd14;

	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_DOLLAR    = 8'h24;
	localparam logic [7:0] CH_CASE_BIT  = 8'h20;

	localparam int TOKEN_LEN_BITS = 8;
	localparam logic [TOKEN_LEN_BITS-1:0] TOKEN_LEN_MAX = 8'hFF;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// only the first three lowercased bytes and the length are kept
	function automatic logic [3:0] mnemonic_kind(input logic [23:0] prefix,
			input logic [7:0] len);
		logic [3:0] k;
		k = KIND_IDENT;
		if (len == 8'd3) begin
			case (prefix)
				24'h6E6F70: k = KIND_NOP;
				24'h616464: k = KIND_ADD;
				24'h737562: k = KIND_SUB;
				24'h636D70: k = KIND_CMP;
				24'h6A6D70: k = KIND_JMP;
				24'h6D6F76: k = KIND_MOV;
				default:    k = KIND_IDENT;
			endcase
		end else if (len == 8'd2) begin
			case (prefix)
				24'h006A61: k = KIND_JA;
				24'h006A62: k = KIND_JB;
				24'h006A65: k = KIND_JE;
				default:    k = KIND_IDENT;
			endcase
		end
		return k;
	endfunction

endpackage

@@ design/assembly_source_tokenizer_core.sv @@
// Assembly source tokenizer: takes one source byte (or an end-of-input mark) per
// transfer and emits tokens with kind, start line, start column and length. A byte
// is registered on arrival and scanned from that register, so a byte can be
// taken every cycle; its zero, one or two tokens go into a four-entry result
// queue drained at one token per cycle while token_ready is high. The input
// stalls only while that queue has fewer than two free slots, so throughput is
// one byte per cycle as long as tokens are taken at least as fast as they are made.
module assembly_source_tokenizer_core import astok_pkg::*; #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      char_valid,
	output logic                      char_ready,
	input  logic [7:0]                char_code,
	input  logic                      end_of_input,
	output logic                      token_valid,
	input  logic                      token_ready,
	output logic [3:0]                token_kind,
	output logic [LINE_BITS-1:0]      token_line,
	output logic [COLUMN_BITS-1:0]    token_column,
	output logic [TOKEN_LEN_BITS-1:0] token_length,
	output logic                      last_result
);

	localparam int ENTRY_BITS = 4 + LINE_BITS + COLUMN_BITS + TOKEN_LEN_BITS + 1;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eof_s1;
	logic       advance, room;

	logic [1:0]                res_count, push_count;
	logic [3:0]                r0_kind, r1_kind;
	logic [LINE_BITS-1:0]      r0_line, r1_line;
	logic [COLUMN_BITS-1:0]    r0_column, r1_column;
	logic [TOKEN_LEN_BITS-1:0] r0_length, r1_length;
	logic                      r0_last;
	logic [ENTRY_BITS-1:0]     din0, din1, dout;

	assign advance    = valid_s1 && room;
	assign char_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (char_ready)
			valid_s1 <= char_valid;
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= char_code;
			eof_s1  <= end_of_input;
		end
	end

	astok_scan #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.char_code    (char_s1),
		.end_of_input (eof_s1),
		.res_count    (res_count),
		.r0_kind      (r0_kind),
		.r0_line      (r0_line),
		.r0_column    (r0_column),
		.r0_length    (r0_length),
		.r0_last      (r0_last),
		.r1_kind      (r1_kind),
		.r1_line      (r1_line),
		.r1_column    (r1_column),
		.r1_length    (r1_length)
	);

	assign push_count = advance ? res_count : 2'd0;
	assign din0 = {r0_kind, r0_line, r0_column, r0_length, r0_last};
	assign din1 = {r1_kind, r1_line, r1_column, r1_length, 1'b1};

	astok_resq #(
		.WIDTH (ENTRY_BITS)
	) u_resq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.din0       (din0),
		.din1       (din1),
		.room       (room),
		.dout_valid (token_valid),
		.dout_ready (token_ready),
		.dout       (dout)
	);

	assign {token_kind, token_line, token_column, token_length, last_result} = dout;

endmodule

@@ design/astok_scan.sv @@
// scanner state, location counters and token formation for one byte per step
module astok_scan import astok_pkg::*; #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [7:0]                char_code,
	input  logic                      end_of_input,
	output logic [1:0]                res_count,
	output logic [3:0]                r0_kind,
	output logic [LINE_BITS-1:0]      r0_line,
	output logic [COLUMN_BITS-1:0]    r0_column,
	output logic [TOKEN_LEN_BITS-1:0] r0_length,
	output logic                      r0_last,
	output logic [3:0]                r1_kind,
	output logic [LINE_BITS-1:0]      r1_line,
	output logic [COLUMN_BITS-1:0]    r1_column,
	output logic [TOKEN_LEN_BITS-1:0] r1_length
);

	localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

	scan_mode_t                mode_q, mode_d;
	logic [23:0]               prefix_q, prefix_d;
	logic [TOKEN_LEN_BITS-1:0] len_q, len_d;
	logic [LINE_BITS-1:0]      line_q, line_d;
	logic [COLUMN_BITS-1:0]    col_q, col_d;
	logic [LINE_BITS-1:0]      sline_q, sline_d;
	logic [COLUMN_BITS-1:0]    scol_q, scol_d;

	logic       eol, brk, alnum, digit, letter;
	logic       in_run, extend, close_v, tail_v;
	logic [7:0] byte_lc;
	logic [3:0] close_kind, tail_kind;
	logic [LINE_BITS-1:0]      tail_line;
	logic [COLUMN_BITS-1:0]    tail_col;
	logic [TOKEN_LEN_BITS-1:0] tail_len;

	always_comb begin
		eol    = char_code == CH_LF || char_code == CH_CR;
		brk    = end_of_input || eol;
		letter = is_letter(char_code);
		digit  = is_digit(char_code);
		alnum  = letter || digit;
		byte_lc = letter ? (char_code | CH_CASE_BIT) : char_code;

		line_d = brk ? line_q + LINE_BITS'(1) : line_q;
		if (brk)
			col_d = '0;
		else if (col_q < COL_MAX)
			col_d = col_q + COLUMN_BITS'(1);
		else
			col_d = col_q;

		in_run = mode_q == MODE_WORD || mode_q == MODE_NUMBER;
		extend = !end_of_input &&
			((mode_q == MODE_WORD && alnum) || (mode_q == MODE_NUMBER && digit));
		close_v    = in_run && !extend;
		close_kind = (mode_q == MODE_WORD) ? mnemonic_kind(prefix_q, len_q) : KIND_INT;

		mode_d   = mode_q;
		prefix_d = prefix_q;
		len_d    = len_q;
		sline_d  = sline_q;
		scol_d   = scol_q;
		tail_v    = 1'b0;
		tail_kind = KIND_UNDEF;
		tail_line = line_d;
		tail_col  = col_d;
		tail_len  = TOKEN_LEN_BITS'(1);

		if (end_of_input) begin
			mode_d    = MODE_IDLE;
			prefix_d  = '0;
			len_d     = '0;
			tail_v    = 1'b1;
			tail_kind = KIND_EOF;
			tail_col  = '0;
			tail_len  = '0;
		end else if (mode_q == MODE_COMMENT) begin
			if (eol)
				mode_d = MODE_IDLE;
		end else if (extend) begin
			if (len_q < TOKEN_LEN_BITS'(3))
				prefix_d = {prefix_q[15:0], byte_lc};
			if (len_q != TOKEN_LEN_MAX)
				len_d = len_q + TOKEN_LEN_BITS'(1);
		end else begin
			// idle, or the run just closed and this byte starts what follows
			if (is_space(char_code)) begin
				mode_d = MODE_IDLE;
			end else if (char_code == CH_SEMICOLON) begin
				mode_d = MODE_COMMENT;
			end else if (alnum) begin
				mode_d   = letter ? MODE_WORD : MODE_NUMBER;
				prefix_d = {16'h0000, byte_lc};
				len_d    = TOKEN_LEN_BITS'(1);
				sline_d  = line_d;
				scol_d   = col_d;
			end else begin
				mode_d = MODE_IDLE;
				tail_v = 1'b1;
				if (char_code == CH_DOLLAR)
					tail_kind = KIND_DOLLAR;
				else if (char_code == CH_COMMA)
					tail_kind = KIND_COMMA;
				else
					tail_kind = KIND_UNDEF;
			end
		end
	end

	always_comb begin
		res_count = {1'b0, close_v} + {1'b0, tail_v};
		if (close_v) begin
			r0_kind   = close_kind;
			r0_line   = sline_q;
			r0_column = scol_q;
			r0_length = len_q;
		end else begin
			r0_kind   = tail_kind;
			r0_line   = tail_line;
			r0_column = tail_col;
			r0_length = tail_len;
		end
		r0_last   = !(close_v && tail_v);
		r1_kind   = tail_kind;
		r1_line   = tail_line;
		r1_column = tail_col;
		r1_length = tail_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			prefix_q <= '0;
			len_q    <= '0;
			line_q   <= '0;
			col_q    <= '0;
			sline_q  <= '0;
			scol_q   <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			prefix_q <= prefix_d;
			len_q    <= len_d;
			line_q   <= line_d;
			col_q    <= col_d;
			sline_q  <= sline_d;
			scol_q   <= scol_d;
		end
	end

endmodule

@@ design/astok_resq.sv @@
// four-entry result queue taking up to two entries per cycle and giving one
module astok_resq #(
	parameter int WIDTH = 41
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_count,
	input  logic [WIDTH-1:0] din0,
	input  logic [WIDTH-1:0] din1,
	output logic             room,
	output logic             dout_valid,
	input  logic             dout_ready,
	output logic [WIDTH-1:0] dout
);

	localparam int DEPTH = 4;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [1:0]       wr_q, rd_q;
	logic [2:0]       cnt_q;
	logic             pop;

	assign pop        = dout_valid && dout_ready;
	assign dout_valid = cnt_q != 3'd0;
	assign dout       = mem_q[rd_q];
	// room means at least two free slots, so a double result never has to wait mid-item
	assign room       = cnt_q <= 3'd2;

	always_ff @(posedge clk) begin
		if (push_count != 2'd0)
			mem_q[wr_q] <= din0;
		if (push_count == 2'd2)
			mem_q[wr_q + 2'd1] <= din1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_count;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_count} - {2'b00, pop};
		end
	end

endmodule

@@ dv/assembly_source_tokenizer_core_tb.sv @@
// self-checking testbench for the assembly source tokenizer core
`timescale 1ns / 100ps

module testbench import astok_pkg::*; ();

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int CALM_ITEMS    = 150;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] line;
		logic [11:0] column;
		logic [7:0]  length;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [7:0] code;
		logic       eof;
		logic       typed;
		token_t     want;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        char_valid;
	logic        char_ready;
	logic [7:0]  char_code;
	logic        end_of_input;
	logic        token_valid;
	logic        token_ready;
	logic [3:0]  token_kind;
	logic [15:0] token_line;
	logic [11:0] token_column;
	logic [7:0]  token_length;
	logic        last_result;

	// scanner state as the tokenizer should hold it
	scan_mode_t  scan_state;
	logic [23:0] word_head;
	logic [7:0]  word_bytes;
	logic [15:0] line_no;
	logic [11:0] col_no;
	logic [15:0] run_line;
	logic [11:0] run_col;

	token_t      expected_tokens[$];
	script_row_t script [23];
	string       mnemonic_text [9] = '{"nop", "add", "sub", "cmp", "ja", "jb", "je", "jmp", "mov"};

	int  errors = 0;
	int  bytes_sent = 0;
	int  tokens_checked = 0;
	int  tx_rate = 0;
	bit  calm = 1'b0;
	bit  hold_req = 1'b0;

	assembly_source_tokenizer_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.token_line   (token_line),
		.token_column (token_column),
		.token_length (token_length),
		.last_result  (last_result)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		errors++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("token %0d %s got %0d want %0d",
				tokens_checked, name, got, want));
	endtask

	function automatic logic [3:0] word_class(input logic [23:0] head, input logic [7:0] n);
		case ({n, head})
			{8'd3, "nop"}:          return KIND_NOP;
			{8'd3, "add"}:          return KIND_ADD;
			{8'd3, "sub"}:          return KIND_SUB;
			{8'd3, "cmp"}:          return KIND_CMP;
			{8'd3, "jmp"}:          return KIND_JMP;
			{8'd3, "mov"}:          return KIND_MOV;
			{8'd2, 8'h00, "ja"}:    return KIND_JA;
			{8'd2, 8'h00, "jb"}:    return KIND_JB;
			{8'd2, 8'h00, "je"}:    return KIND_JE;
			default:                return KIND_IDENT;
		endcase
	endfunction

	function automatic token_t closed_run();
		token_t t;
		t.kind   = (scan_state == MODE_NUMBER) ? KIND_INT : word_class(word_head, word_bytes);
		t.line   = run_line;
		t.column = run_col;
		t.length = word_bytes;
		t.last   = 1'b0;
		return t;
	endfunction

	task automatic take_byte(input logic [7:0] b);
		if (word_bytes < 8'd3)
			word_head = {word_head[15:0], b};
		if (word_bytes != 8'hFF)
			word_bytes++;
	endtask

	task automatic begin_run(input scan_mode_t m, input logic [7:0] b);
		scan_state = m;
		word_head  = '0;
		word_bytes = '0;
		run_line   = line_no;
		run_col    = col_no;
		take_byte(b);
	endtask

	// tokens that one accepted byte (or end mark) should produce
	task automatic scan_byte(input logic [7:0] c, input logic eof, output token_t found[$]);
		logic   letter, digit, blank, brk;
		logic [7:0] lower;
		token_t t;
		found  = {};
		letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		digit  = c >= "0" && c <= "9";
		blank  = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		brk    = eof || c == CH_LF || c == CH_CR;
		lower  = letter ? (c | CH_CASE_BIT) : c;

		if (brk) begin
			line_no++;
			col_no = '0;
		end else if (col_no != '1) begin
			col_no++;
		end

		if (eof) begin
			if (scan_state == MODE_WORD || scan_state == MODE_NUMBER)
				found = {found, closed_run()};
			t = '{KIND_EOF, line_no, 12'd0, 8'd0, 1'b0};
			found = {found, t};
			scan_state = MODE_IDLE;
			word_head  = '0;
			word_bytes = '0;
		end else if (scan_state == MODE_COMMENT) begin
			if (brk)
				scan_state = MODE_IDLE;
		end else if (scan_state == MODE_WORD && (letter || digit)) begin
			take_byte(lower);
		end else if (scan_state == MODE_NUMBER && digit) begin
			take_byte(c);
		end else begin
			// the byte that ends a run is scanned again from idle
			if (scan_state == MODE_WORD || scan_state == MODE_NUMBER) begin
				found = {found, closed_run()};
				scan_state = MODE_IDLE;
			end
			if (blank) begin
			end else if (c == CH_SEMICOLON) begin
				scan_state = MODE_COMMENT;
			end else if (letter) begin
				begin_run(MODE_WORD, lower);
			end else if (digit) begin
				begin_run(MODE_NUMBER, c);
			end else begin
				t.kind   = (c == CH_DOLLAR) ? KIND_DOLLAR : (c == CH_COMMA) ? KIND_COMMA : KIND_UNDEF;
				t.line   = line_no;
				t.column = col_no;
				t.length = 8'd1;
				t.last   = 1'b0;
				found = {found, t};
			end
		end
		if (found.size() != 0)
			found[found.size() - 1].last = 1'b1;
	endtask

	// one byte transfer, with an occasional random gap ahead of it
	task automatic offer(input logic [7:0] c, input logic eof = 1'b0,
			input logic typed = 1'b0, input token_t want = '0);
		token_t found[$];
		int gap;
		if (!calm && tx_rate != 0 && $urandom_range(0, 9) < tx_rate) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			char_valid   <= 1'b0;
			char_code    <= 8'($urandom_range(0, 255));
			end_of_input <= 1'($urandom_range(0, 1));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		char_valid   <= 1'b1;
		char_code    <= c;
		end_of_input <= eof;
		do @(posedge clk); while (!char_ready);
		scan_byte(c, eof, found);
		if (typed)
			expected_tokens = {expected_tokens, want};
		else
			expected_tokens = {expected_tokens, found};
		bytes_sent++;
		if (bytes_sent % 100 == 0)
			tx_rate = $urandom_range(0, 3);
	endtask

	// sender pause until every token has come out
	task automatic drain();
		@(negedge clk);
		char_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] random_letter();
		return 8'("a" + $urandom_range(0, 25)) ^ ($urandom_range(0, 1) ? CH_CASE_BIT : 8'h00);
	endfunction

	function automatic logic [7:0] random_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	task automatic emit_blanks();
		repeat ($urandom_range(1, 3)) offer($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	task automatic emit_mnemonic();
		string w;
		w = mnemonic_text[$urandom_range(0, 8)];
		foreach (w[i]) offer(w[i] ^ ($urandom_range(0, 1) ? CH_CASE_BIT : 8'h00));
	endtask

	task automatic emit_ident();
		offer(random_letter());
		repeat ($urandom_range(0, 6))
			offer($urandom_range(0, 2) == 0 ? random_digit() : random_letter());
	endtask

	task automatic emit_operand();
		case ($urandom_range(0, 4))
			0: begin
				offer(CH_DOLLAR);
				repeat ($urandom_range(1, 5)) offer(random_digit());
			end
			1: repeat ($urandom_range(1, 5)) offer(random_digit());
			2: emit_ident();
			// a mnemonic with a tail only shares its first bytes
			3: begin
				emit_mnemonic();
				offer(random_letter());
			end
			default: emit_mnemonic();
		endcase
	endtask

	task automatic emit_line();
		int pick, n_ops;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0)
			emit_blanks();
		if (pick < 8) begin
			repeat ($urandom_range(1, 6)) offer(8'($urandom_range(0, 255)));
		end else if (pick >= 18) begin
			if (pick < 80)
				emit_mnemonic();
			else
				emit_ident();
			n_ops = $urandom_range(0, 2);
			for (int k = 0; k < n_ops; k++) begin
				if (k != 0) begin
					if ($urandom_range(0, 2) == 0)
						emit_blanks();
					offer(CH_COMMA);
					if ($urandom_range(0, 1) == 0)
						emit_blanks();
				end else begin
					emit_blanks();
				end
				emit_operand();
			end
		end
		if ((pick >= 8 && pick < 18) || $urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 1) == 0)
				emit_blanks();
			offer(CH_SEMICOLON);
			repeat ($urandom_range(0, 8)) begin
				do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
				offer(c);
			end
		end
		case ($urandom_range(0, 24))
			0:       offer(8'($urandom_range(0, 255)), 1'b1);
			1, 2, 3: offer(CH_CR);
			4, 5, 6: begin
				offer(CH_CR);
				offer(CH_LF);
			end
			default: offer(CH_LF);
		endcase
	endtask

	// checks every token transfer against the oldest expectation
	always @(posedge clk) begin : token_check
		token_t got, want;
		if (arst_n === 1'b1 && token_valid && token_ready) begin
			got = '{token_kind, token_line, token_column, token_length, last_result};
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected token kind %0d line %0d column %0d",
					got.kind, got.line, got.column));
			end else begin
				want = expected_tokens.pop_front();
				check_field("kind", int'(got.kind), int'(want.kind));
				check_field("line", int'(got.line), int'(want.line));
				check_field("column", int'(got.column), int'(want.column));
				check_field("length", int'(got.length), int'(want.length));
				check_field("last", int'(got.last), int'(want.last));
			end
			tokens_checked++;
		end
	end

	initial begin : token_sink
		int rate, window, stall;
		token_ready = 1'b0;
		rate = 0;
		window = 0;
		forever begin
			@(negedge clk);
			if (window == 0) begin
				rate = $urandom_range(0, 3);
				window = $urandom_range(50, 300);
			end
			window--;
			if (hold_req) begin
				// long stall so the token queue fills and the input backs up
				hold_req = 1'b0;
				token_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && rate != 0 && $urandom_range(0, 9) < rate) begin
				stall = $urandom_range(1, 18);
				token_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				token_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("assembly_source_tokenizer_core regression: fail");
		$finish;
	end

	initial begin : stimulus
		int first_random;
		arst_n       = 1'b0;
		char_valid   = 1'b0;
		char_code    = '0;
		end_of_input = 1'b0;
		scan_state   = MODE_IDLE;
		word_head    = '0;
		word_bytes   = '0;
		line_no      = '0;
		col_no       = '0;
		run_line     = '0;
		run_col      = '0;

		script = '{
			'{8'hA5, 1'b1, 1'b1, '{KIND_EOF, 16'd1, 12'd0, 8'd0, 1'b1}},
			'{CH_DOLLAR, 1'b0, 1'b1, '{KIND_DOLLAR, 16'd1, 12'd1, 8'd1, 1'b1}},
			'{CH_COMMA, 1'b0, 1'b1, '{KIND_COMMA, 16'd1, 12'd2, 8'd1, 1'b1}},
			'{8'hFF, 1'b0, 1'b1, '{KIND_UNDEF, 16'd1, 12'd3, 8'd1, 1'b1}},
			'{8'h00, 1'b0, 1'b1, '{KIND_UNDEF, 16'd1, 12'd4, 8'd1, 1'b1}},
			'{"J", 1'b0, 1'b0, '0},
			'{"A", 1'b0, 1'b0, '0},
			'{CH_TAB, 1'b0, 1'b0, '0},
			'{"N", 1'b0, 1'b0, '0},
			'{"O", 1'b0, 1'b0, '0},
			'{"p", 1'b0, 1'b0, '0},
			'{CH_COMMA, 1'b0, 1'b0, '0},
			'{CH_SEMICOLON, 1'b0, 1'b0, '0},
			'{"x", 1'b0, 1'b0, '0},
			'{CH_LF, 1'b0, 1'b0, '0},
			'{CH_SEMICOLON, 1'b0, 1'b0, '0},
			'{"q", 1'b0, 1'b0, '0},
			'{CH_CR, 1'b0, 1'b0, '0},
			'{"0", 1'b0, 1'b0, '0},
			'{"9", 1'b0, 1'b0, '0},
			'{"9", 1'b0, 1'b0, '0},
			'{8'h5A, 1'b1, 1'b0, '0},
			'{CH_DOLLAR, 1'b0, 1'b0, '0}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			offer(script[i].code, script[i].eof, script[i].typed, script[i].want);
		drain();

		// output held off while bytes keep coming
		hold_req = 1'b1;
		repeat (40) offer($urandom_range(0, 1) ? CH_DOLLAR : CH_COMMA);
		drain();

		first_random = bytes_sent;
		while (bytes_sent < first_random + RANDOM_ITEMS / 2)
			emit_line();

		// saturating token length on a long word and a long number
		calm = 1'b1;
		offer(CH_LF);
		repeat (260) offer("q");
		offer(CH_SPACE);
		repeat (260) offer("7");
		offer(CH_LF);
		calm = 1'b0;
		drain();

		first_random = bytes_sent;
		while (bytes_sent < first_random + RANDOM_ITEMS / 2 - CALM_ITEMS)
			emit_line();
		calm = 1'b1;
		while (bytes_sent < first_random + RANDOM_ITEMS / 2)
			emit_line();
		offer(8'($urandom_range(0, 255)), 1'b1);
		drain();

		$display("covered %0d source bytes and %0d tokens: mnemonics, words, numbers, comments,",
			bytes_sent, tokens_checked);
		$display("end marks, stray bytes, length saturation and a long output stall");
		if (errors == 0 && expected_tokens.size() == 0)
			$display("assembly_source_tokenizer_core regression: pass");
		else
			$display("assembly_source_tokenizer_core regression: fail");
		$finish;
	end

endmodule
